/* src/ird_pkg.sv */
// Shared types, constants and helpers for the integer-to-radix-digits block.
`timescale 1ns / 1ps

package ird_pkg;

    localparam int NUM_W        = 32;
    localparam int BASE_W       = 6;
    localparam int STEP_W       = $clog2(NUM_W);
    localparam int ALPHA_WORDS  = 4;
    localparam int ALPHA_IDX_W  = 5;
    localparam int WR_IDX_W     = 3;
    localparam int CFG_DATA_W   = 64;
    localparam int MAX_BASE_DEF = 32;

    localparam logic [WR_IDX_W-1:0] REG_BASE_LEN = 3'd0;
    localparam logic [WR_IDX_W-1:0] REG_ALPHA_0  = 3'd1;
    localparam logic [WR_IDX_W-1:0] REG_ALPHA_1  = 3'd2;
    localparam logic [WR_IDX_W-1:0] REG_ALPHA_2  = 3'd3;
    localparam logic [WR_IDX_W-1:0] REG_ALPHA_3  = 3'd4;

    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;

    typedef logic [ALPHA_WORDS-1:0][7:0][7:0] alpha_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_ERR,
        S_DIV,
        S_SIGN,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic done;
        logic err;
    } chk_status_t;

    typedef struct packed {
        logic              done;
        logic [NUM_W-1:0]  quotient;
        logic [BASE_W-1:0] remainder;
    } div_result_t;

    function automatic logic [7:0] alpha_char(alpha_t words, logic [ALPHA_IDX_W-1:0] pos);
        return words[pos[ALPHA_IDX_W-1:3]][pos[2:0]];
    endfunction

endpackage

/* src/int_to_radix_digits.sv */
// Top level: renders a signed 32-bit number as text in a configured radix and alphabet.
`timescale 1ns / 1ps

// Each accepted number produces one character transfer per output character: a minus sign
// for negatives, then the digits most significant first, the final one marked by last. An
// invalid alphabet (radix below two or above MAX_BASE, a plus or minus sign, or a repeated
// character) yields a single transfer with is_error set and out_char zero. The block handles
// one number at a time. An item goes through the alphabet check (one character per cycle),
// then the bit-serial divider once per digit (one quotient bit per cycle, 32 bits), then the
// output register, which takes a character whenever it is free; in_ready returns as soon as
// the last character sits in the output register.
module int_to_radix_digits #(
    parameter int MAX_BASE = ird_pkg::MAX_BASE_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [ird_pkg::WR_IDX_W-1:0]   wr_index,
    input  logic [ird_pkg::CFG_DATA_W-1:0] wr_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [ird_pkg::NUM_W-1:0] number,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [7:0]                     out_char,
    output logic                           is_error,
    output logic                           last
);
    import ird_pkg::*;

    localparam int DIGIT_W = (MAX_BASE > 2) ? $clog2(MAX_BASE) : 1;
    localparam int CNT_W   = $clog2(NUM_W + 1);

    state_t            state_reg, state_next;
    logic [BASE_W-1:0] base_len_reg;
    alpha_t            alpha_reg;
    logic              neg_reg;
    logic [NUM_W-1:0]  mag_reg;
    logic [NUM_W-1:0][DIGIT_W-1:0] stack_reg, stack_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_char_reg;
    logic              is_error_reg, last_reg;

    chk_status_t       chk;
    div_result_t       div_res;
    logic              chk_start, div_start;
    logic [NUM_W-1:0]  div_dividend;
    logic              slot_free, push, pop, load_out;
    logic [7:0]        load_char;
    logic              load_err, load_last;
    logic              accept;

    assign slot_free = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;

    ird_alpha_check #(
        .MAX_BASE (MAX_BASE)
    ) u_check (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (chk_start),
        .base_len (base_len_reg),
        .alphabet (alpha_reg),
        .status   (chk)
    );

    ird_serial_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (base_len_reg),
        .result   (div_res)
    );

    // Configuration registers; writes to unused indexes fall through.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_len_reg <= '0;
            alpha_reg    <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_BASE_LEN: base_len_reg <= wr_data[BASE_W-1:0];
                REG_ALPHA_0:  alpha_reg[0] <= wr_data;
                REG_ALPHA_1:  alpha_reg[1] <= wr_data;
                REG_ALPHA_2:  alpha_reg[2] <= wr_data;
                REG_ALPHA_3:  alpha_reg[3] <= wr_data;
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (in_valid)
                    state_next = S_CHECK;
            S_CHECK:
                if (chk.done)
                    state_next = chk.err ? S_ERR : S_DIV;
            S_ERR:
                if (slot_free)
                    state_next = S_IDLE;
            S_DIV:
                if (div_res.done && (div_res.quotient == '0))
                    state_next = neg_reg ? S_SIGN : S_EMIT;
            S_SIGN:
                if (slot_free)
                    state_next = S_EMIT;
            S_EMIT:
                if (slot_free && (cnt_reg == CNT_W'(1)))
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        chk_start    = 1'b0;
        div_start    = 1'b0;
        div_dividend = div_res.quotient;
        push         = 1'b0;
        pop          = 1'b0;
        load_out     = 1'b0;
        load_char    = '0;
        load_err     = 1'b0;
        load_last    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready  = 1'b1;
                chk_start = in_valid;
            end
            S_CHECK:
            begin
                div_start    = chk.done && !chk.err;
                div_dividend = mag_reg;
            end
            S_ERR:
            begin
                load_out  = slot_free;
                load_err  = 1'b1;
                load_last = 1'b1;
            end
            S_DIV:
            begin
                push      = div_res.done;
                div_start = div_res.done && (div_res.quotient != '0);
            end
            S_SIGN:
            begin
                load_out  = slot_free;
                load_char = CHAR_MINUS;
            end
            S_EMIT:
            begin
                load_out  = slot_free;
                pop       = slot_free;
                load_char = alpha_char(alpha_reg, ALPHA_IDX_W'(stack_reg[0]));
                load_last = (cnt_reg == CNT_W'(1));
            end
            default: ;
        endcase
    end

    // Digits come out least significant first, so a shift-register stack reverses them.
    always_comb
    begin
        stack_next = stack_reg;
        cnt_next   = cnt_reg;
        if (accept)
            cnt_next = '0;
        else if (push)
        begin
            stack_next = {stack_reg[NUM_W-2:0], div_res.remainder[DIGIT_W-1:0]};
            cnt_next   = CNT_W'(cnt_reg + 1'b1);
        end
        else if (pop)
        begin
            stack_next = stack_reg >> DIGIT_W;
            cnt_next   = CNT_W'(cnt_reg - 1'b1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stack_reg <= stack_next;
        if (accept)
        begin
            neg_reg <= number[NUM_W-1];
            mag_reg <= number[NUM_W-1] ? NUM_W'(-number) : NUM_W'(number);
        end
        if (load_out)
        begin
            out_char_reg <= load_char;
            is_error_reg <= load_err;
            last_reg     <= load_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign is_error  = is_error_reg;
    assign last      = last_reg;

endmodule

/* src/ird_alpha_check.sv */
// Serial alphabet check: one character per cycle against the characters before it.
`timescale 1ns / 1ps

module ird_alpha_check #(
    parameter int MAX_BASE = ird_pkg::MAX_BASE_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [ird_pkg::BASE_W-1:0] base_len,
    input  ird_pkg::alpha_t            alphabet,
    output ird_pkg::chk_status_t       status
);
    import ird_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic              err_reg, err_next;
    logic [BASE_W-1:0] idx_reg, idx_next;
    logic [7:0]        ch;
    logic              dup;
    logic              bad;
    logic              at_end;

    assign ch = alpha_char(alphabet, idx_reg[ALPHA_IDX_W-1:0]);

    // A repeat shows up as a match against any character earlier in the alphabet.
    always_comb
    begin
        dup = 1'b0;
        for (int j = 0; j < ALPHA_WORDS * 8; j++)
        begin
            if ((BASE_W'(j) < idx_reg) && (alpha_char(alphabet, ALPHA_IDX_W'(j)) == ch))
                dup = 1'b1;
        end
    end

    assign bad    = (ch == CHAR_PLUS) || (ch == CHAR_MINUS) || dup;
    assign at_end = (BASE_W'(idx_reg + 1'b1) == base_len);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        err_next  = err_reg;
        idx_next  = idx_reg;
        if (start)
        begin
            idx_next  = '0;
            err_next  = 1'b0;
            if ((base_len < BASE_W'(2)) || (base_len > BASE_W'(MAX_BASE)))
            begin
                done_next = 1'b1;
                err_next  = 1'b1;
            end
            else
            begin
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            idx_next = BASE_W'(idx_reg + 1'b1);
            if (bad || at_end)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                err_next  = bad;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            err_reg  <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            err_reg  <= err_next;
            idx_reg  <= idx_next;
        end
    end

    assign status.done = done_reg;
    assign status.err  = err_reg;

endmodule

/* src/ird_serial_div.sv */
// Bit-serial restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps

module ird_serial_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [ird_pkg::NUM_W-1:0]  dividend,
    input  logic [ird_pkg::BASE_W-1:0] divisor,
    output ird_pkg::div_result_t       result
);
    import ird_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0]  work_reg, work_next;
    logic [BASE_W-1:0] rem_reg, rem_next;
    logic [BASE_W:0]   trial;
    logic              qbit;

    // The partial remainder stays below the divisor, so one extra bit holds the trial.
    assign trial = {rem_reg, work_reg[NUM_W-1]};
    assign qbit  = (trial >= {1'b0, divisor});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        work_next = work_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            work_next = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            work_next = {work_reg[NUM_W-2:0], qbit};
            rem_next  = qbit ? BASE_W'(trial - {1'b0, divisor}) : BASE_W'(trial);
            cnt_next  = STEP_W'(cnt_reg + 1'b1);
            if (cnt_reg == STEP_W'(NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
    end

    assign result.done      = done_reg;
    assign result.quotient  = work_reg;
    assign result.remainder = rem_reg;

endmodule

/* src/ird_checker.sv */
// Port-level checks for the integer-to-radix-digits block, bound to its top level.
`timescale 1ns / 1ps

module ird_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic [7:0]                        out_char,
    input logic                              is_error,
    input logic                              last
);
    import ird_pkg::*;

    // An error result is a single transfer with a zero character.
    a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_error) |-> (last && (out_char == '0)))
        else $error("error result is not a lone zero character");

    // A minus sign can only be the sign, so it is never the final character.
    a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !is_error && (out_char == CHAR_MINUS)) |-> !last)
        else $error("minus sign marked as last character");

    // One number at a time: after a transfer in, the input side closes.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while an item is in progress");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(out_char) && $stable(is_error) && $stable(last)))
        else $error("stalled result changed or dropped");

endmodule

bind int_to_radix_digits ird_checker u_ird_checker (.*);

/* dv/testbench.sv */
// Self-checking testbench for int_to_radix_digits: directed and random numbers, varied flow.
`timescale 1ns / 1ps

module testbench;
    import ird_pkg::*;

    localparam int HALF_PERIOD = 2;
    localparam int RADIX_MAX = MAX_BASE_DEF;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int TAIL_CYCLES = 200;
    localparam int MAX_REPORTS = 10;
    localparam int BATCHES_PER_PHASE = 7;
    localparam int ITEMS_PER_BATCH = 9;

    // Indexes past the last alphabet word; the block must ignore writes to them.
    localparam logic [WR_IDX_W-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [WR_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [7:0] ch;
        logic       err;
        logic       fin;
    } text_char_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  wr_en = 1'b0;
    logic [WR_IDX_W-1:0]   wr_index = '0;
    logic [CFG_DATA_W-1:0] wr_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic signed [NUM_W-1:0] number = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [7:0]            out_char;
    logic                  is_error;
    logic                  last;

    // Shadow copy of the configuration registers.
    logic [BASE_W-1:0] radix_cfg = '0;
    alpha_t            alpha_cfg = '0;

    logic [NUM_W-1:0] pending_numbers[$];
    text_char_t       expected_chars[$];

    int send_idle_pct = 6;
    int recv_stall_pct = 83;
    int error_count = 0;
    int cycle_count = 0;

    int_to_radix_digits DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .number   (number),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_char (out_char),
        .is_error (is_error),
        .last     (last)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // Works out the text of one number under the current alphabet.
    function automatic void render_number(input logic [NUM_W-1:0] value);
        logic [NUM_W-1:0] mag;
        logic [7:0]       c;
        logic [4:0]       digits[NUM_W];
        bit [255:0]       seen;
        bit               ok;
        int               nd;
        int               i;

        seen = '0;
        ok = (radix_cfg >= 2) && (radix_cfg <= RADIX_MAX);
        for (i = 0; ok && i < radix_cfg; i++)
        begin
            c = alpha_cfg[i / 8][i % 8];
            if (c == CHAR_PLUS || c == CHAR_MINUS || seen[c])
                ok = 1'b0;
            seen[c] = 1'b1;
        end
        if (!ok)
        begin
            expected_chars.push_back('{ch: 8'h00, err: 1'b1, fin: 1'b1});
            return;
        end

        mag = value[NUM_W-1] ? -value : value;
        nd = 0;
        do
        begin
            digits[nd] = 5'(mag % radix_cfg);
            mag = mag / radix_cfg;
            nd++;
        end while (mag != 0);

        if (value[NUM_W-1])
            expected_chars.push_back('{ch: CHAR_MINUS, err: 1'b0, fin: 1'b0});
        for (i = nd - 1; i >= 0; i--)
            expected_chars.push_back('{ch: alpha_cfg[digits[i] / 8][digits[i] % 8],
                                       err: 1'b0, fin: (i == 0)});
    endfunction

    function automatic alpha_t text_alphabet(input string s);
        alpha_t a;
        int     i;

        a = '0;
        for (i = 0; i < s.len(); i++)
            a[i / 8][i % 8] = s[i];
        return a;
    endfunction

    // Thirty-two distinct characters, none of them a sign.
    function automatic alpha_t random_alphabet();
        alpha_t     a;
        bit [255:0] used;
        logic [7:0] b;
        int         i;

        used = '0;
        used[CHAR_PLUS] = 1'b1;
        used[CHAR_MINUS] = 1'b1;
        for (i = 0; i < RADIX_MAX; i++)
        begin
            b = 8'($urandom_range(255));
            while (used[b])
                b = 8'($urandom_range(255));
            used[b] = 1'b1;
            a[i / 8][i % 8] = b;
        end
        return a;
    endfunction

    function automatic logic [NUM_W-1:0] pick_number(input int radix);
        logic [63:0]      p;
        logic [NUM_W-1:0] v;
        int               sel;
        int               k;
        int               r;

        r = (radix < 2 || radix > RADIX_MAX) ? 2 : radix;
        sel = $urandom_range(9);
        if (sel < 4)
            return $urandom;
        if (sel < 6)
            v = $urandom_range(r * r);
        else if (sel < 8)
        begin
            // Values next to a power of the radix change the digit count.
            p = 1;
            k = $urandom_range(1, 31);
            repeat (k)
                if (p * r < 64'h8000_0000)
                    p = p * r;
            v = p[NUM_W-1:0] + $urandom_range(2) - 1;
        end
        else
        begin
            case ($urandom_range(3))
                0: return 32'h7FFF_FFFF;
                1: return 32'h8000_0000;
                2: return 32'hFFFF_FFFF;
                default: return 32'h0000_0000;
            endcase
        end
        return $urandom_range(1) ? -v : v;
    endfunction

    task automatic write_reg(input logic [WR_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= data;
        case (idx)
            REG_BASE_LEN: radix_cfg = data[BASE_W-1:0];
            REG_ALPHA_0:  alpha_cfg[0] = data;
            REG_ALPHA_1:  alpha_cfg[1] = data;
            REG_ALPHA_2:  alpha_cfg[2] = data;
            REG_ALPHA_3:  alpha_cfg[3] = data;
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(posedge clk);
        wr_en <= 1'b0;
    endtask

    task automatic load_config(input logic [BASE_W-1:0] radix, input alpha_t alpha);
        write_reg(REG_BASE_LEN, CFG_DATA_W'(radix));
        write_reg(REG_ALPHA_0, alpha[0]);
        write_reg(REG_ALPHA_1, alpha[1]);
        write_reg(REG_ALPHA_2, alpha[2]);
        write_reg(REG_ALPHA_3, alpha[3]);
        end_writes();
    endtask

    // Returns once every queued number has been taken and every character has come back.
    task automatic wait_drained();
        @(negedge clk);
        while (pending_numbers.size() != 0 || in_valid || expected_chars.size() != 0)
            @(negedge clk);
    endtask

    task automatic random_batch();
        alpha_t            alpha;
        logic [BASE_W-1:0] radix;
        int                i;
        int                j;

        radix = BASE_W'($urandom_range(2, RADIX_MAX));
        alpha = random_alphabet();
        // A sign past the used part of the alphabet must not matter.
        if (radix < RADIX_MAX && $urandom_range(3) == 0)
        begin
            i = $urandom_range(radix, RADIX_MAX - 1);
            alpha[i / 8][i % 8] = $urandom_range(1) ? CHAR_PLUS : CHAR_MINUS;
        end
        case ($urandom_range(9))
            0:
            begin
                i = $urandom_range(radix - 2);
                j = $urandom_range(i + 1, radix - 1);
                alpha[j / 8][j % 8] = alpha[i / 8][i % 8];
            end
            1:
            begin
                i = $urandom_range(radix - 1);
                alpha[i / 8][i % 8] = $urandom_range(1) ? CHAR_PLUS : CHAR_MINUS;
            end
            2: radix = BASE_W'($urandom_range(1) ? $urandom_range(1) : $urandom_range(33, 63));
            default: ;
        endcase
        load_config(radix, alpha);
        for (i = 0; i < ITEMS_PER_BATCH; i++)
            pending_numbers.push_back(pick_number(radix));
        wait_drained();
    endtask

    // Driver: presents queued numbers and predicts the text of each one taken.
    always @(posedge clk)
    begin : drive_proc
        if (in_valid && in_ready)
            render_number(number);
        if (!in_valid || in_ready)
        begin
            if (rst_n && pending_numbers.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                number <= pending_numbers.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Monitor: throttles the character channel and checks each transfer.
    always @(posedge clk)
    begin : monitor_proc
        text_char_t want;

        if (rst_n)
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_chars.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("unexpected character transfer: char %h err %b last %b",
                             out_char, is_error, last);
            end
            else
            begin
                want = expected_chars.pop_front();
                if (out_char !== want.ch || is_error !== want.err || last !== want.fin)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display({"mismatch: expected char %h err %b last %b, ",
                                  "got char %h err %b last %b"},
                                 want.ch, want.err, want.fin, out_char, is_error, last);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin : stimulus_proc
        alpha_t alpha;
        int     phase;
        int     b;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Registers still hold their reset values: radix zero is an invalid alphabet.
        pending_numbers.push_back(32'd7);
        wait_drained();

        load_config(6'd10, text_alphabet("0123456789"));
        pending_numbers = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                            32'd1000000000, -32'sd42};
        wait_drained();

        // Binary gives the longest text: a sign and thirty-two digits.
        load_config(6'd2, text_alphabet("01"));
        pending_numbers = '{32'h8000_0000, 32'h7FFF_FFFF, 32'd5};
        wait_drained();

        // Full-size alphabet with a zero byte and an all-ones byte as ordinary characters.
        alpha = text_alphabet("0123456789ABCDEFGHIJKLMNOPQRSTUV");
        alpha[0][5] = 8'h00;
        alpha[3][7] = 8'hFF;
        load_config(6'd32, alpha);
        pending_numbers = '{32'd5, -32'sd1024, 32'h7FFF_FFFF};
        wait_drained();

        load_config(6'd16, text_alphabet("0123456789abcdef"));
        write_reg(REG_SPARE_LO, {CFG_DATA_W{1'b1}});
        write_reg(REG_SPARE_HI, '0);
        end_writes();
        pending_numbers = '{32'd255, -32'sd256};
        wait_drained();

        // Invalid alphabets, one number each.
        load_config(6'd1, text_alphabet("0123456789"));
        pending_numbers.push_back(32'd3);
        wait_drained();
        load_config(6'd33, random_alphabet());
        pending_numbers.push_back(32'd3);
        wait_drained();
        load_config(6'd63, random_alphabet());
        pending_numbers.push_back(32'd3);
        wait_drained();
        load_config(6'd12, text_alphabet("01234567"));
        pending_numbers.push_back(32'd9);
        wait_drained();
        load_config(6'd10, text_alphabet("01234+6789"));
        pending_numbers.push_back(32'd9);
        wait_drained();
        load_config(6'd10, text_alphabet("012345678-"));
        pending_numbers.push_back(-32'sd9);
        wait_drained();
        // A sign just past the used characters is allowed.
        load_config(6'd3, text_alphabet("abc+"));
        pending_numbers.push_back(-32'sd100);
        wait_drained();

        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 6;
                    recv_stall_pct = 83;
                end
                1:
                begin
                    send_idle_pct = 83;
                    recv_stall_pct = 6;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
            endcase
            for (b = 0; b < BATCHES_PER_PHASE; b++)
                random_batch();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0 && expected_chars.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* int_to_radix_digits.f */
src/ird_pkg.sv
src/ird_alpha_check.sv
src/ird_serial_div.sv
src/int_to_radix_digits.sv
src/ird_checker.sv
dv/testbench.sv
